// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the start-of-frame receiver with resync.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned FRAME_LEN  = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = $clog2(FRAME_LEN);
  localparam int unsigned CFG_IDX_W  = 1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID   = 1'b1;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_ID_ERR  = 2'd1,
    ST_SUM_ERR = 2'd2
  } frame_status_t;

  typedef struct packed {
    frame_status_t status;
    byte_t         command;
    byte_t         b3;
    byte_t         b2;
    byte_t         b1;
    byte_t         b0;
  } result_t;

endpackage

// ===== rtl/sfr_frame_core.sv =====
// ----------------------------------------------------------------------------
// sfr_frame_core
// Frame store, fill count, frame check and realignment on a failed frame.
// ----------------------------------------------------------------------------
module sfr_frame_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  sfr_pkg::byte_t   rx_byte,
  input  sfr_pkg::byte_t   start_byte,
  input  sfr_pkg::byte_t   frame_id,
  output logic             res_valid,
  output sfr_pkg::result_t res_data
);

  localparam int unsigned N = sfr_pkg::FRAME_LEN;

  sfr_pkg::byte_t frame_store      [N];
  sfr_pkg::byte_t frame_store_next [N];
  sfr_pkg::byte_t wr_store         [N];
  sfr_pkg::byte_t shifted          [N];
  sfr_pkg::pos_t  fill_count;
  sfr_pkg::pos_t  fill_count_next;
  sfr_pkg::pos_t  sync_pos;
  sfr_pkg::byte_t head_sum;
  sfr_pkg::frame_status_t status;
  logic           head_match;
  logic           done;
  logic           found;
  logic [sfr_pkg::POS_W:0] src_idx;

  // Write the byte at the fill position
  always_comb begin
    for (int i = 0; i < N; i++) begin
      wr_store[i] = frame_store[i];
    end
    wr_store[fill_count] = rx_byte;
  end

  assign head_match = (wr_store[0] == start_byte);
  assign done       = head_match && (fill_count == sfr_pkg::pos_t'(N - 1));

  always_comb begin
    head_sum = '0;
    for (int i = 0; i < N - 1; i++) begin
      head_sum = head_sum + wr_store[i];
    end
  end

  always_comb begin
    if (wr_store[1] != frame_id) begin
      status = sfr_pkg::ST_ID_ERR;
    end else if (wr_store[N-1] != head_sum) begin
      status = sfr_pkg::ST_SUM_ERR;
    end else begin
      status = sfr_pkg::ST_VALID;
    end
  end

  // Lowest position after the head that holds a start byte
  always_comb begin
    found    = 1'b0;
    sync_pos = '0;
    for (int i = N - 1; i >= 1; i--) begin
      if (wr_store[i] == start_byte) begin
        found    = 1'b1;
        sync_pos = sfr_pkg::pos_t'(i);
      end
    end
  end

  // Move the tail down; positions past the moved bytes keep their contents
  always_comb begin
    for (int i = 0; i < N; i++) begin
      src_idx    = (sfr_pkg::POS_W+1)'(i) + {1'b0, sync_pos};
      shifted[i] = wr_store[i];
      if (src_idx < (sfr_pkg::POS_W+1)'(N)) begin
        shifted[i] = wr_store[src_idx[sfr_pkg::POS_W-1:0]];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      frame_store_next[i] = wr_store[i];
    end
    fill_count_next = fill_count;
    if (done) begin
      fill_count_next = '0;
      if (status != sfr_pkg::ST_VALID && found) begin
        for (int i = 0; i < N; i++) begin
          frame_store_next[i] = shifted[i];
        end
        fill_count_next = sfr_pkg::pos_t'((sfr_pkg::POS_W+1)'(N) - {1'b0, sync_pos});
      end
    end else if (head_match) begin
      fill_count_next = fill_count + sfr_pkg::pos_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      for (int i = 0; i < N; i++) begin
        frame_store[i] <= '0;
      end
    end else if (accept) begin
      fill_count <= fill_count_next;
      for (int i = 0; i < N; i++) begin
        frame_store[i] <= frame_store_next[i];
      end
    end
  end

  assign res_valid        = accept && done;
  assign res_data.status  = status;
  assign res_data.command = wr_store[2];
  assign res_data.b3      = wr_store[3];
  assign res_data.b2      = wr_store[4];
  assign res_data.b1      = wr_store[5];
  assign res_data.b0      = wr_store[6];

endmodule

// ===== rtl/sfr_result_buf.sv =====
// ----------------------------------------------------------------------------
// sfr_result_buf
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module sfr_result_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sfr_pkg::result_t push_data,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output sfr_pkg::result_t out_data
);

  logic             skid_valid;
  sfr_pkg::result_t skid_data;
  logic             take;

  assign take = !out_valid || out_ready;
  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

// ===== rtl/sof_frame_receiver_resync_core.sv =====
// ----------------------------------------------------------------------------
// sof_frame_receiver_resync_core
// Start-of-frame deframer: collects 8-byte frames, checks id and additive
// checksum, and resyncs on the next start byte after a failed frame.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | word
//  ---------+----------------------+-----------------------------------------
//  in       | in_valid / in_ready  | rx_byte
//  out      | out_valid/ out_ready | frame_status, command, payload_b3..b0
//  cfg      | cfg_valid/ cfg_ready | cfg_index, cfg_data (0 start, 1 id)
//
//  One byte a cycle while in_ready is high: each word is written, checked
//  and realigned in the cycle it is accepted, and a finished frame lands in
//  the result register, or in its skid entry while that register is stalled, on the same edge.
//  Reset clears the frame store, fill count, both registers and the result
//  path; the block takes words as soon as reset is released.
//  in_ready drops only while the result register and its skid entry both
//  hold a word; cfg_ready is always high.
//
module sof_frame_receiver_resync_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       frame_status,
  output logic [7:0]                       command,
  output logic [7:0]                       payload_b3,
  output logic [7:0]                       payload_b2,
  output logic [7:0]                       payload_b1,
  output logic [7:0]                       payload_b0,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                       cfg_data
);

  sfr_pkg::byte_t   start_byte;
  sfr_pkg::byte_t   frame_id;
  logic             accept;
  logic             res_valid;
  sfr_pkg::result_t res_data;
  sfr_pkg::result_t out_data;
  logic             room;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
      frame_id   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sfr_pkg::CFG_START_BYTE: start_byte <= cfg_data;
        sfr_pkg::CFG_FRAME_ID:   frame_id   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold input only when no slot is left for a result
  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  sfr_frame_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (rx_byte),
    .start_byte (start_byte),
    .frame_id   (frame_id),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

  sfr_result_buf u_rbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign frame_status = out_data.status;
  assign command      = out_data.command;
  assign payload_b3   = out_data.b3;
  assign payload_b2   = out_data.b2;
  assign payload_b1   = out_data.b1;
  assign payload_b0   = out_data.b0;

endmodule

// ===== rtl/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks for the start-of-frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] frame_status
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Input is held back only while a result is on show
  a_stall_needs_result: assert property (@(posedge clk)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A new result needs a word accepted on the edge before
  a_result_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted word");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_status == sfr_pkg::ST_VALID ||
                   frame_status == sfr_pkg::ST_ID_ERR ||
                   frame_status == sfr_pkg::ST_SUM_ERR))
    else $error("undefined frame status");

endmodule

bind sof_frame_receiver_resync_core sfr_checker u_sfr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_status (frame_status)
);
